@@ hw/rtl/bmrf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_pkg
// shared types and constants of the bank mapper register file
// ----------------------------------------------------------------------------
package bmrf_pkg;
  localparam int EXP_RAM_BYTES_DEF = 1024;
  localparam int PRG_BANK_BITS_DEF = 7;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_PRG   = 3'd3;
  localparam logic [2:0] OP_CHR   = 3'd4;

  localparam logic [15:0] A_PRG_MODE = 16'h5100;
  localparam logic [15:0] A_CHR_MODE = 16'h5101;
  localparam logic [15:0] A_EXP_MODE = 16'h5104;
  localparam logic [15:0] A_NT_MAP   = 16'h5105;
  localparam logic [15:0] A_FILL_T   = 16'h5106;
  localparam logic [15:0] A_FILL_C   = 16'h5107;
  localparam logic [15:0] A_PRG_BANK = 16'h5114;
  localparam logic [15:0] A_CHR_BANK = 16'h5120;
  localparam logic [15:0] A_CHR_HIGH = 16'h5130;
  localparam logic [15:0] A_IRQ_CMP  = 16'h5203;
  localparam logic [15:0] A_IRQ_STAT = 16'h5204;
  localparam logic [15:0] A_MUL_A    = 16'h5205;
  localparam logic [15:0] A_MUL_B    = 16'h5206;
  localparam logic [15:0] A_EXP_RAM  = 16'h5C00;
  localparam logic [8:0]  LINE_VBL   = 9'd241;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] address;
    logic [7:0]  value;
    logic [8:0]  line_number;
    logic        tall_sprites;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_pulse;
    logic [19:0] mapped_offset;
    logic        mapped_is_rom;
    logic [7:0]  nametable_select;
    logic [7:0]  fill_tile_byte;
    logic [7:0]  fill_attr_byte;
  } result_t;

  // result of the register stage, with a flag that selects the registered ram read data
  typedef struct packed {
    result_t res;
    logic    ram_rd;
  } stage_t;
endpackage
`default_nettype wire

@@ hw/rtl/bank_mapper_register_file.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bank_mapper_register_file
// cartridge bank controller: registers, translation, irq and expansion ram
// ----------------------------------------------------------------------------
// s_axis carries one request beat (write, read, tick, prg or chr translate);
// m_axis returns exactly one result beat per request, in order.
// the register stage decides and issues the expansion ram access; the
// ram registers its byte alongside the register stage, and the merged
// result lands in an output register. one beat per cycle is sustained
// while the receiver is ready. when the receiver stalls the pipeline holds
// and s_axis_tready drops only once both the register stage and the output
// register hold a beat and the receiver is not ready.
// reset (rst, synchronous) restores the control registers and valid flags
// to their power-up values and holds s_axis_tready low; expansion ram
// contents are undefined until written. no clearing pass.
// ----------------------------------------------------------------------------
module bank_mapper_register_file #(
  parameter int EXP_RAM_BYTES = bmrf_pkg::EXP_RAM_BYTES_DEF,
  parameter int PRG_BANK_BITS = bmrf_pkg::PRG_BANK_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], address[18:3], value[26:19], line_number[35:27], pad
  input  wire  [39:0] s_axis_tdata,
  // tall_sprites
  input  wire         s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // read_data[7:0], irq_pulse[8], mapped_offset[28:9], mapped_is_rom[29],
  // nametable_select[37:30], fill_tile_byte[45:38], fill_attr_byte[53:46], pad
  output logic [55:0] m_axis_tdata
);
  import bmrf_pkg::*;
  localparam int AW = $clog2(EXP_RAM_BYTES);

  item_t   item;
  stage_t  stage;
  logic    go, s1_valid, adv;
  logic    ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0] ram_rdata;
  result_t s1_res;
  result_t out_res;

  assign item = '{op: s_axis_tdata[2:0], address: s_axis_tdata[18:3],
                  value: s_axis_tdata[26:19], line_number: s_axis_tdata[35:27],
                  tall_sprites: s_axis_tuser};

  // stage 1 drains into output when output is empty or being taken
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !rst && (adv || !s1_valid);
  assign go = s_axis_tvalid && s_axis_tready;

  bmrf_regs #(.PRG_BANK_BITS(PRG_BANK_BITS), .EXP_RAM_BYTES(EXP_RAM_BYTES)) u_regs (
    .clk(clk), .rst(rst), .go(go), .item(item), .stage(stage),
    .ram_en(ram_en), .ram_we(ram_we), .ram_addr(ram_addr)
  );

  bmrf_exp_ram #(.DEPTH(EXP_RAM_BYTES)) u_ram (
    .clk(clk), .en(ram_en && go), .we(ram_we), .addr(ram_addr),
    .wdata(item.value), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_valid && adv) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (go) s1_valid <= 1'b1;
      else if (adv) s1_valid <= 1'b0;
    end
  end

  always_comb begin
    s1_res = stage.res;
    if (stage.ram_rd) s1_res.read_data = ram_rdata;
  end

  always_ff @(posedge clk) begin
    if (s1_valid && adv) out_res <= s1_res;
  end

  assign m_axis_tdata = {2'd0, out_res.fill_attr_byte, out_res.fill_tile_byte,
                         out_res.nametable_select, out_res.mapped_is_rom,
                         out_res.mapped_offset, out_res.irq_pulse, out_res.read_data};

  assert property (@(posedge clk) disable iff (rst)
    go |=> s1_valid)
    else $error("accepted beat lost in stage one");
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |-> !s_axis_tready)
    else $error("beat accepted while pipeline full");
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv |=> m_axis_tvalid)
    else $error("stage one beat not delivered");
endmodule
`default_nettype wire

@@ hw/rtl/bmrf_exp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_exp_ram
// expansion ram, one write or read port, registered read data
// ----------------------------------------------------------------------------
module bmrf_exp_ram #(
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     en,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [7:0]               wdata,
  output logic [7:0]              rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bmrf_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_regs
// control registers, translation and irq logic; one item per cycle
// ----------------------------------------------------------------------------
module bmrf_regs #(
  parameter int PRG_BANK_BITS = bmrf_pkg::PRG_BANK_BITS_DEF,
  parameter int EXP_RAM_BYTES = bmrf_pkg::EXP_RAM_BYTES_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             go,
  input  wire bmrf_pkg::item_t            item,
  output bmrf_pkg::stage_t                stage,
  output logic                            ram_en,
  output logic                            ram_we,
  output logic [$clog2(EXP_RAM_BYTES)-1:0] ram_addr
);
  import bmrf_pkg::*;
  localparam int AW = $clog2(EXP_RAM_BYTES);

  logic [1:0] prg_size, chr_high, exp_mode;
  logic [7:0] prg_bank [4];
  logic [9:0] chr_bank [12];
  logic [9:0] chr_win [8];
  logic [7:0] nt_map, fill_tile, fill_color, irq_cmp, mul_a, mul_b;
  logic       irq_en, frame_on, pending;
  logic [15:0] product;

  logic        is_exp, is_prg_bank, is_chr_bank, wr, rd;
  logic [15:0] a;
  logic [3:0]  chr_r;
  logic [9:0]  chr_v;
  logic [7:0]  rd_data, pb;
  logic [PRG_BANK_BITS-1:0] bank;
  logic [1:0]  slot, preg;
  logic [19:0] poff;
  logic [19:0] coff;
  logic [1:0]  c;

  assign a = item.address;
  assign is_exp = a >= A_EXP_RAM && a <= 16'h5FFF;
  assign is_prg_bank = a >= A_PRG_BANK && a <= A_PRG_BANK + 16'd3;
  assign is_chr_bank = a >= A_CHR_BANK && a <= A_CHR_BANK + 16'd11;
  assign wr = go && item.op == OP_WRITE;
  assign rd = go && item.op == OP_READ;
  assign chr_r = 4'(a - A_CHR_BANK);
  assign chr_v = {chr_high, item.value};
  assign product = mul_a * mul_b;

  assign ram_en = (wr && is_exp && exp_mode != 2'd3) || (rd && is_exp);
  assign ram_we = wr;
  assign ram_addr = AW'(a - A_EXP_RAM);

  always_comb begin
    case (a)
      A_IRQ_STAT: rd_data = {pending, frame_on, 6'd0};
      A_MUL_A:    rd_data = product[7:0];
      A_MUL_B:    rd_data = product[15:8];
      default:    rd_data = 8'hFF;
    endcase
  end

  always_comb begin
    slot = a[14:13];
    case (prg_size)
      2'd0:    preg = 2'd3;
      2'd1:    preg = slot[1] ? 2'd3 : 2'd1;
      2'd2:    preg = slot[1] ? slot : 2'd1;
      default: preg = slot;
    endcase
    pb = prg_bank[preg];
    bank = pb[PRG_BANK_BITS-1:0];
    case (prg_size)
      2'd0:    poff = 20'({bank, 13'd0} & ~20'h07FFF) | {5'd0, a[14:0]};
      2'd1:    poff = 20'({bank, 13'd0} & ~20'h03FFF) | {6'd0, a[13:0]};
      2'd2:    poff = slot[1] ? (20'({bank, 13'd0}) | {7'd0, a[12:0]})
                              : (20'({bank, 13'd0} & ~20'h03FFF) | {6'd0, a[13:0]});
      default: poff = 20'({bank, 13'd0}) | {7'd0, a[12:0]};
    endcase
    coff = {chr_win[a[12:10]], a[9:0]};
  end

  assign c = fill_color[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_size <= 2'd3; chr_high <= 2'd0; exp_mode <= 2'd0;
      for (int i = 0; i < 4; i++) prg_bank[i] <= 8'hFF;
      for (int i = 0; i < 12; i++) chr_bank[i] <= (i < 8) ? 10'(i) : 10'd0;
      for (int i = 0; i < 8; i++) chr_win[i] <= 10'(i);
      nt_map <= 8'd0; fill_tile <= 8'hFF; fill_color <= 8'hFF; irq_cmp <= 8'd0;
      mul_a <= 8'hFF; mul_b <= 8'hFF;
      irq_en <= 1'b0; frame_on <= 1'b0; pending <= 1'b0;
    end else if (go) begin
      if (wr) begin
        if (is_prg_bank) prg_bank[a[1:0]] <= item.value;
        if (is_chr_bank) begin
          chr_bank[chr_r] <= chr_v;
          chr_win[chr_r[3] ? 3'(chr_r - 4'd4) : chr_r[2:0]] <= chr_v;
        end
        case (a)
          A_PRG_MODE: prg_size <= item.value[1:0];
          A_CHR_MODE: begin
            if (item.value[1:0] == 2'd3)
              for (int i = 0; i < 8; i++)
                chr_win[i] <= item.tall_sprites ? chr_bank[8 + (i % 4)] : chr_bank[i];
          end
          A_EXP_MODE: exp_mode <= item.value[1:0];
          A_NT_MAP:   nt_map <= item.value;
          A_FILL_T:   fill_tile <= item.value;
          A_FILL_C:   fill_color <= item.value;
          A_CHR_HIGH: chr_high <= item.value[1:0];
          A_IRQ_CMP:  irq_cmp <= item.value;
          A_IRQ_STAT: irq_en <= item.value[7];
          A_MUL_A:    mul_a <= item.value;
          A_MUL_B:    mul_b <= item.value;
          default: ;
        endcase
      end
      if (rd && a == A_IRQ_STAT) pending <= 1'b0;
      if (go && item.op == OP_TICK) begin
        if (item.line_number >= LINE_VBL) frame_on <= 1'b0;
        else begin
          frame_on <= 1'b1;
          if (item.line_number == {1'b0, irq_cmp}) pending <= 1'b1;
        end
      end
    end
  end

  // payload: uses state before this beat except nt/fill, which follow the write
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.ram_rd <= 1'b0;
    end else if (go) begin
      stage.ram_rd <= rd && is_exp;
      stage.res.read_data <= (item.op == OP_READ && !is_exp) ? rd_data : 8'd0;
      stage.res.irq_pulse <= item.op == OP_TICK && item.line_number < LINE_VBL &&
                             item.line_number == {1'b0, irq_cmp} && irq_en;
      stage.res.mapped_offset <= (item.op == OP_PRG && a[15]) ? poff :
                                 (item.op == OP_CHR) ? coff : 20'd0;
      stage.res.mapped_is_rom <= item.op == OP_PRG && a[15] && pb[7];
      stage.res.nametable_select <= (wr && a == A_NT_MAP) ? item.value : nt_map;
      stage.res.fill_tile_byte <= (wr && a == A_FILL_T) ? item.value : fill_tile;
      stage.res.fill_attr_byte <= (wr && a == A_FILL_C) ? {4{item.value[1:0]}} : {4{c}};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ram_en && ram_we |-> wr && exp_mode != 2'd3)
    else $error("exp ram written while locked");
  assert property (@(posedge clk) disable iff (rst)
    go && item.op == OP_READ && a == A_IRQ_STAT |=> !pending)
    else $error("status read did not clear pending");
  assert property (@(posedge clk) disable iff (rst)
    stage.res.irq_pulse |-> pending)
    else $error("pulse without pending");
endmodule
`default_nettype wire
